>>> design/pcmr_pkg.sv
// Shared types, constants and helper functions for the PCM resampler.
`timescale 1ns / 1ps
`default_nettype none

package pcmr_pkg;

  localparam int unsigned MAX_SAMPLES_DEFAULT = 65536;
  localparam int unsigned COS_TABLE_SIZE      = 256;
  localparam int          COS_IDX_W           = $clog2(COS_TABLE_SIZE);

  localparam int SAMPLE_W    = 16;
  localparam int CNT_W       = 17;
  localparam int POS_W       = 32;
  localparam int IDX_W       = 16;
  localparam int W_W         = 17;
  localparam int CO_W        = 20;
  localparam int MA_W        = 38;
  localparam int MB_W        = W_W + 1;
  localparam int ACC_W       = MA_W + MB_W;
  localparam int RES_W       = 24;
  localparam int FETCH_CNT_W = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int SAT_MAX     = 32767;
  localparam int SAT_MIN     = -32768;

  // pi in Q8.24
  localparam logic [63:0] PI_Q24 = 64'd52707178;

  typedef enum logic [1:0] {
    MODE_NEAREST = 2'd0,
    MODE_LINEAR  = 2'd1,
    MODE_COSINE  = 2'd2,
    MODE_CUBIC   = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE      = 2'd0,
    CFG_IN_COUNT  = 2'd1,
    CFG_OUT_COUNT = 2'd2,
    CFG_STEP      = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_EMIT = 1'b1
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_FETCH,
    ST_CALC,
    ST_MUL,
    ST_BFIN,
    ST_ADD1,
    ST_MUL2,
    ST_ADD2,
    ST_MUL3,
    ST_MUL4,
    ST_ADD3,
    ST_FIN,
    ST_OUT
  } state_t;

  // Cosine blend weight (1 - cos(pi*k/COS_TABLE_SIZE)) / 2 in Q16, built from a
  // twelve-term Taylor series in Q8.24. Only called with constant arguments.
  function automatic logic [W_W-1:0] cos_weight(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic [63:0]        w;
    logic signed [63:0] acc;
    x   = PI_Q24 * 64'(k) / 64'(COS_TABLE_SIZE);
    x2  = (x * x) >> 24;
    t   = 64'd1 << 24;
    acc = '0;
    for (int n = 1; n <= 12; n++) begin
      t = t * x2 / 64'((2 * n - 1) * (2 * n));
      if (n[0]) begin
        acc = acc + $signed(t);
      end else begin
        acc = acc - $signed(t);
      end
    end
    if (acc < 0) begin
      acc = '0;
    end
    w = (64'(acc) + 64'd256) >> 9;
    if (w > 64'd65536) begin
      w = 64'd65536;
    end
    return w[W_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [RES_W-1:0] v);
    if (v > RES_W'(SAT_MAX)) begin
      return SAMPLE_W'(SAT_MAX);
    end else if (v < RES_W'(SAT_MIN)) begin
      return SAMPLE_W'(SAT_MIN);
    end else begin
      return v[SAMPLE_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> design/pcmr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module pcmr_ram
  import pcmr_pkg::*;
#(
  parameter int unsigned WIDTH = SAMPLE_W,
  parameter int unsigned DEPTH = MAX_SAMPLES_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> design/pcm_resampler_interp_unit.sv
// Load requests are taken only in idle. An emit runs prep, the window fetch and calc, then
// output (nearest), multiply and blend (linear, cosine) or the multiply-add chain (cubic),
// and no new request is taken until its result is loaded. The four window reads through
// the single sample-store read port and the shared multiplier in the cubic chain set this.
// Reset restores the registers to their defaults and clears the write pointer, output index
// and position; the sample store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module pcm_resampler_interp_unit
  import pcmr_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [SAMPLE_W-1:0]  s_axis_tdata,   // [15:0] sample_in
  input  wire logic                 s_axis_tuser,   // [0] action
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic      [SAMPLE_W-1:0]  m_axis_tdata,   // [15:0] sample_out
  output logic                      m_axis_tlast,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [POS_W-1:0]     cfg_data
);

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int NW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;

  localparam logic signed [ACC_W-1:0] BLEND_RND  = ACC_W'(65535);
  localparam logic signed [ACC_W-1:0] CUB_RND_NZ = ACC_W'(64'sh1_0000_0000);
  localparam logic signed [ACC_W-1:0] CUB_RND_Z  = ACC_W'(64'sh0_FFFF_FFFF);

  // Configuration and pass state
  mode_t              mode;
  logic [CNT_W-1:0]   in_count;
  logic [CNT_W-1:0]   out_count;
  logic [POS_W-1:0]   step_q16;
  logic [AW:0]        wp;
  logic [IDX_W-1:0]   output_index;
  logic [POS_W-1:0]   position_acc;

  // Sequencer
  state_t                 state;
  state_t                 state_next;
  logic [FETCH_CNT_W-1:0] cnt;

  // Datapath
  logic [AW-1:0]               a_idx;
  logic [AW-1:0]               last_idx;
  logic [AW-1:0]               rd_addr;
  logic [AW:0]                 a_p2;
  logic [15:0]                 frac;
  logic [SAMPLE_W-1:0]         rd_data;
  logic signed [SAMPLE_W-1:0]  win [4];
  logic signed [CO_W-1:0]      c0;
  logic signed [CO_W-1:0]      c1;
  logic signed [CO_W-1:0]      c2;
  logic signed [CO_W-1:0]      c0_c;
  logic [W_W-1:0]              w;
  logic signed [MA_W-1:0]      mul_a;
  logic signed [MB_W-1:0]      mul_b;
  logic signed [ACC_W-1:0]     mul_p;
  logic signed [ACC_W-1:0]     prod;
  logic signed [ACC_W-1:0]     acc;
  logic signed [ACC_W-1:0]     p2;
  logic signed [ACC_W-1:0]     blend_sum;
  logic signed [ACC_W-1:0]     blend_adj;
  logic signed [ACC_W-1:0]     cub_adj;
  logic [15:0]                 lo;
  logic                        r_nz;
  logic signed [SAMPLE_W-1:0]  res;
  logic [W_W-1:0]              cos_tab [COS_TABLE_SIZE];
  logic [COS_IDX_W-1:0]        cos_idx;

  logic [NW-1:0] in_ext;
  logic [NW-1:0] n_val;
  logic [NW-1:0] a_ext;
  logic          a_clamp;
  logic          in_acc;
  logic          load_we;
  logic          out_last;
  logic          out_load;

  assign cfg_ready = 1'b1;
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign load_we   = in_acc && (s_axis_tuser == ACT_LOAD) && (wp != (AW + 1)'(MAX_SAMPLES));
  assign out_last  = (({1'b0, output_index} + CNT_W'(1)) == out_count);
  assign out_load  = (state == ST_OUT) && (!m_axis_tvalid || m_axis_tready);

  pcmr_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (load_we),
    .waddr (wp[AW-1:0]),
    .wdata (s_axis_tdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  for (genvar k = 0; k < COS_TABLE_SIZE; k++) begin : g_cos
    assign cos_tab[k] = cos_weight(k);
  end

  assign cos_idx = COS_IDX_W'((POS_W'(frac) * COS_TABLE_SIZE) >> 16);

  // Effective clip length and clamped integer position.
  always_comb begin
    in_ext = NW'(in_count);
    if (in_count == '0) begin
      n_val = NW'(1);
    end else if (in_ext > NW'(MAX_SAMPLES)) begin
      n_val = NW'(MAX_SAMPLES);
    end else begin
      n_val = in_ext;
    end
    a_ext   = NW'(position_acc[POS_W-1:16]);
    a_clamp = (a_ext >= n_val);
  end

  assign a_p2  = {1'b0, a_idx} + (AW + 1)'(2);
  assign mul_b = $signed({1'b0, w});
  assign mul_p = mul_a * mul_b;

  assign c0_c = CO_W'(win[3]) - CO_W'(win[2]) - CO_W'(win[0]) + CO_W'(win[1]);
  assign p2   = prod + (ACC_W'(c2) <<< 32);

  assign blend_sum = (ACC_W'(win[1]) <<< 16) + prod;
  assign blend_adj = blend_sum[ACC_W-1] ? blend_sum + BLEND_RND : blend_sum;

  // Truncation toward zero of (acc + r/65536) / 2^32 where r is the dropped remainder.
  assign cub_adj = acc[ACC_W-1] ? acc + (r_nz ? CUB_RND_NZ : CUB_RND_Z) : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    rd_addr       = a_idx;
    mul_a         = MA_W'(c0);
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && (s_axis_tuser == ACT_EMIT)) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        state_next = ST_FETCH;
      end
      ST_FETCH: begin
        // Window a-1, a, a+1, a+2, each clamped to the clip.
        case (cnt[1:0])
          2'd0: rd_addr = (a_idx == '0) ? '0 : a_idx - AW'(1);
          2'd1: rd_addr = a_idx;
          2'd2: rd_addr = (a_idx == last_idx) ? last_idx : a_idx + AW'(1);
          2'd3: rd_addr = (a_p2 > {1'b0, last_idx}) ? last_idx : a_p2[AW-1:0];
          default: rd_addr = a_idx;
        endcase
        if (cnt == FETCH_CNT_W'(4)) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        state_next = (mode == MODE_NEAREST) ? ST_OUT : ST_MUL;
      end
      ST_MUL: begin
        mul_a      = MA_W'(c0);
        state_next = (mode == MODE_CUBIC) ? ST_ADD1 : ST_BFIN;
      end
      ST_BFIN: begin
        state_next = ST_OUT;
      end
      ST_ADD1: begin
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        mul_a      = acc[MA_W-1:0];
        state_next = ST_ADD2;
      end
      ST_ADD2: begin
        state_next = ST_MUL3;
      end
      ST_MUL3: begin
        mul_a      = acc[MA_W-1:0];
        state_next = ST_MUL4;
      end
      ST_MUL4: begin
        mul_a      = $signed({{(MA_W - 16){1'b0}}, lo});
        state_next = ST_ADD3;
      end
      ST_ADD3: begin
        state_next = ST_FIN;
      end
      ST_FIN: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == ST_FETCH) begin
      cnt <= cnt + FETCH_CNT_W'(1);
    end else begin
      cnt <= '0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_PREP: begin
        last_idx <= AW'(n_val - NW'(1));
        a_idx    <= a_clamp ? AW'(n_val - NW'(1)) : AW'(a_ext);
        frac     <= a_clamp ? '0 : position_acc[15:0];
      end
      ST_FETCH: begin
        if (cnt != '0) begin
          win[3] <= $signed(rd_data);
          win[2] <= win[3];
          win[1] <= win[2];
          win[0] <= win[1];
        end
      end
      ST_CALC: begin
        // For linear and cosine, c0 carries the neighbor difference.
        c0  <= (mode == MODE_CUBIC) ? c0_c : CO_W'(win[2]) - CO_W'(win[1]);
        c1  <= CO_W'(win[0]) - CO_W'(win[1]) - c0_c;
        c2  <= CO_W'(win[2]) - CO_W'(win[0]);
        w   <= (mode == MODE_COSINE) ? cos_tab[cos_idx] : W_W'(frac);
        res <= win[1];
      end
      ST_MUL, ST_MUL2, ST_MUL3: begin
        prod <= mul_p;
      end
      ST_MUL4: begin
        prod <= mul_p;
        acc  <= prod + (ACC_W'(win[1]) <<< 32);
      end
      ST_ADD1: begin
        acc <= prod + (ACC_W'(c1) <<< 16);
      end
      ST_ADD2: begin
        acc <= p2 >>> 16;
        lo  <= p2[15:0];
      end
      ST_ADD3: begin
        acc  <= acc + (prod >>> 16);
        r_nz <= |prod[15:0];
      end
      ST_BFIN: begin
        res <= sat16(blend_adj[16 +: RES_W]);
      end
      ST_FIN: begin
        res <= sat16(cub_adj[32 +: RES_W]);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_LINEAR;
      in_count     <= CNT_W'(1);
      out_count    <= CNT_W'(1);
      step_q16     <= POS_W'(65536);
      wp           <= '0;
      output_index <= '0;
      position_acc <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_MODE:      mode      <= mode_t'(cfg_data[1:0]);
          CFG_IN_COUNT:  in_count  <= cfg_data[CNT_W-1:0];
          CFG_OUT_COUNT: out_count <= cfg_data[CNT_W-1:0];
          CFG_STEP:      step_q16  <= cfg_data;
          default: begin
          end
        endcase
      end
      if (load_we) begin
        wp <= wp + (AW + 1)'(1);
      end
      if (out_load) begin
        // The flagged last output ends the pass and rewinds the position.
        if (out_last) begin
          output_index <= '0;
          position_acc <= '0;
        end else begin
          output_index <= output_index + IDX_W'(1);
          position_acc <= position_acc + step_q16;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= res;
      m_axis_tlast <= out_last;
    end
  end

`ifndef ASSERT_OFF
  a_pass_rewind: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_last) |=> (output_index == '0 && position_acc == '0))
    else $error("pass did not rewind after the last output");

  a_store_full: assert property (@(posedge clk) disable iff (rst)
    (in_acc && s_axis_tuser == ACT_LOAD && wp == (AW + 1)'(MAX_SAMPLES)) |=> $stable(wp))
    else $error("write pointer moved past a full store");

  a_index_in_clip: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE && state != ST_PREP) |-> (a_idx <= last_idx))
    else $error("sample index beyond the clip");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_OUT))
    else $error("result appeared outside the output step");
`endif

endmodule

`default_nettype wire

>>> dv/pcm_resampler_interp_unit_tb.sv
// Self-checking testbench for the PCM resampler: random load/emit streams against a predictor.
`timescale 1ns / 1ps

module pcm_resampler_interp_unit_tb;
  import pcmr_pkg::*;

  localparam int          CLIP_DEPTH   = 65536;
  localparam int          COS_ENTRIES  = 256;
  localparam longint      PI_Q8_24     = 64'd52707178;
  localparam int          PHASES       = 42;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          IDLE_PAUSE   = 24;
  localparam int unsigned CYCLE_LIMIT  = 800000;

  typedef struct packed {
    action_t             act;
    logic [SAMPLE_W-1:0] pcm;
  } pcm_req_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] pcm;
    logic                tail;
  } pcm_res_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [SAMPLE_W-1:0]  s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [SAMPLE_W-1:0]  m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [POS_W-1:0]     cfg_data = '0;

  pcm_resampler_interp_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #2 clk = ~clk;

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // Shadow of the block: register copies, clip contents and pass position.
  mode_t                 cur_mode   = MODE_LINEAR;
  logic [CNT_W-1:0]      cur_in     = 17'd1;
  logic [CNT_W-1:0]      cur_out    = 17'd1;
  logic [POS_W-1:0]      cur_stride = 32'd65536;
  logic signed [15:0]    clip_mem [0:CLIP_DEPTH-1];
  int unsigned           clip_len   = 0;
  logic [IDX_W-1:0]      out_idx    = '0;
  logic [POS_W-1:0]      pos_acc    = '0;

  pcm_req_t pending_reqs[$];
  pcm_res_t expected_pcm[$];

  int send_idle_pct = 34;
  int recv_idle_pct = 60;
  int hold_req      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int errors        = 0;
  int loads_taken   = 0;
  int emits_taken   = 0;
  int results_seen  = 0;
  int pass_ends     = 0;
  int reg_writes    = 0;
  int unsigned cycles = 0;

  // Raised-cosine weight (1 - cos(pi*k/256)) / 2 in Q16 from a Q8.24 Taylor series.
  function automatic longint unsigned raised_cos_q16(int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned w;
    longint          acc;
    x   = PI_Q8_24 * 64'(k) / 64'(COS_ENTRIES);
    x2  = (x * x) >> 24;
    t   = 64'd1 << 24;
    acc = 0;
    for (int unsigned i = 1; i <= 12; i++) begin
      t = t * x2 / 64'((2 * i - 1) * (2 * i));
      if (i % 2 == 1) begin
        acc = acc + longint'(t);
      end else begin
        acc = acc - longint'(t);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    w = (64'(acc) + 64'd256) >> 9;
    if (w > 64'd65536) begin
      w = 64'd65536;
    end
    return w;
  endfunction

  function automatic longint lerp_q16(longint s0, longint s1, longint w);
    return (s0 * 65536 + w * (s1 - s0)) / 65536;
  endfunction

  // Four-point polynomial evaluated exactly at 128 bits, truncated toward zero.
  function automatic longint cubic_q48(longint s0, longint s1, longint s2, longint s3,
                                       longint f);
    logic signed [127:0] c0;
    logic signed [127:0] c1;
    logic signed [127:0] c2;
    logic signed [127:0] ff;
    logic signed [127:0] base;
    logic signed [127:0] total;
    logic signed [127:0] scale;
    c0    = s3 - s2 - s0 + s1;
    c1    = s0 - s1 - c0;
    c2    = s2 - s0;
    ff    = f;
    base  = s1;
    scale = 128'sd1 <<< 48;
    total = c0 * ff * ff * ff + ((c1 * ff * ff) <<< 16) + ((c2 * ff) <<< 32) + (base <<< 48);
    return longint'(total / scale);
  endfunction

  function automatic logic [15:0] sat_pcm16(longint v);
    if (v > 32767) begin
      return 16'h7FFF;
    end else if (v < -32768) begin
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  task automatic apply_request(pcm_req_t r);
    int unsigned n;
    int unsigned a;
    int unsigned f;
    longint      v;
    longint      w;
    pcm_res_t    res;
    if (r.act == ACT_LOAD) begin
      // A full clip ignores further loads.
      if (clip_len < CLIP_DEPTH) begin
        clip_mem[clip_len] = r.pcm;
        clip_len++;
      end
      loads_taken++;
    end else begin
      n = cur_in;
      if (n < 1) n = 1;
      if (n > CLIP_DEPTH) n = CLIP_DEPTH;
      a = pos_acc[31:16];
      f = pos_acc[15:0];
      if (a > n - 1) begin
        a = n - 1;
        f = 0;
      end
      case (cur_mode)
        MODE_NEAREST: begin
          v = clip_mem[a];
        end
        MODE_LINEAR, MODE_COSINE: begin
          if (a >= n - 1) begin
            v = clip_mem[n-1];
          end else begin
            w = (cur_mode == MODE_COSINE) ? longint'(raised_cos_q16(f >> 8)) : longint'(f);
            v = lerp_q16(clip_mem[a], clip_mem[a+1], w);
          end
        end
        default: begin
          v = cubic_q48((a == 0) ? clip_mem[0] : clip_mem[a-1], clip_mem[a],
                        (a + 1 >= n) ? clip_mem[n-1] : clip_mem[a+1],
                        (a + 2 >= n) ? clip_mem[n-1] : clip_mem[a+2], f);
        end
      endcase
      res.pcm  = sat_pcm16(v);
      res.tail = ((32'(out_idx) + 32'd1) == 32'(cur_out));
      expected_pcm.push_back(res);
      if (res.tail) begin
        out_idx = '0;
        pos_acc = '0;
      end else begin
        out_idx = out_idx + 1'b1;
        pos_acc = pos_acc + cur_stride;
      end
      emits_taken++;
    end
  endtask

  // Driver: presents queued requests, feeding each accepted one to the predictor.
  always @(posedge clk) begin : req_driver
    pcm_req_t r;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        r.act = action_t'(s_axis_tuser);
        r.pcm = s_axis_tdata;
        apply_request(r);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          r = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= r.pcm;
          s_axis_tuser  <= r.act;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: throttles the result stream and checks every accepted result in order.
  always @(posedge clk) begin : res_monitor
    pcm_res_t e;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (m_axis_tlast === 1'b1) pass_ends++;
        if (expected_pcm.size() == 0) begin
          errors++;
          if (errors <= 50)
            $display("%0t: unexpected result sample_out %0d last %0b", $time,
                     $signed(m_axis_tdata), m_axis_tlast);
        end else begin
          e = expected_pcm.pop_front();
          if (m_axis_tdata !== e.pcm || m_axis_tlast !== e.tail) begin
            errors++;
            if (errors <= 50)
              $display("%0t: mismatch sample_out exp %0d got %0d, last exp %0b got %0b",
                       $time, $signed(e.pcm), $signed(m_axis_tdata), e.tail, m_axis_tlast);
          end
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen     <= hold_req;
        hold_left     <= HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_pcm.size() != 0)
      @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MODE:      cur_mode   = mode_t'(val[1:0]);
      CFG_IN_COUNT:  cur_in     = val[CNT_W-1:0];
      CFG_OUT_COUNT: cur_out    = val[CNT_W-1:0];
      default:       cur_stride = val;
    endcase
    reg_writes++;
  endtask

  task automatic program_regs(mode_t m, logic [31:0] inc, logic [31:0] outc,
                              logic [31:0] stride);
    write_reg(CFG_MODE, 32'(m));
    write_reg(CFG_IN_COUNT, inc);
    write_reg(CFG_OUT_COUNT, outc);
    write_reg(CFG_STEP, stride);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_req(action_t act, logic [15:0] pcm);
    pcm_req_t r;
    r.act = act;
    r.pcm = pcm;
    pending_reqs.push_back(r);
  endtask

  function automatic logic [15:0] rand_pcm();
    case ($urandom_range(0, 11))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int unsigned inc;
    int unsigned outc;
    int unsigned stride;
    int          n_emit;
    logic [15:0] seed_clip [7];
    @(negedge rst);
    @(posedge clk);

    // Directed: a clip of extremes, then every mode over the same positions. The window
    // at 1.5 makes the cubic overshoot, and position 6 lands on the last sample.
    seed_clip = '{16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001};
    foreach (seed_clip[i]) push_req(ACT_LOAD, seed_clip[i]);
    for (int m = 0; m < 4; m++) begin
      wait_idle();
      program_regs(mode_t'(m), 7, 5, 32'h0001_8000);
      repeat (5) push_req(ACT_EMIT, 16'($urandom));
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      if (ph == PHASES / 3) begin
        send_idle_pct = 60;
        recv_idle_pct = 34;
      end else if (ph == 2 * PHASES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ($urandom_range(0, 9))
        0:       inc = 0;
        1:       inc = clip_len;
        2:       inc = 1;
        default: inc = $urandom_range(1, clip_len);
      endcase
      // Mostly close the open pass within a few outputs so that last is seen often.
      case ($urandom_range(0, 9))
        0:       outc = 0;
        1:       outc = 17'h1FFFF;
        2:       outc = 65536;
        default: outc = 32'(out_idx) + $urandom_range(1, 16);
      endcase
      case ($urandom_range(0, 9))
        0:       stride = 0;
        1:       stride = 1;
        2:       stride = 32'hFFFF_FFFF;
        3:       stride = $urandom;
        4:       stride = 32'h0001_0000;
        default: stride = $urandom_range(1, 32'h0003_0000);
      endcase
      if (ph == 0) stride = 0;
      if (ph == 1) stride = 1;
      if (ph == 2) outc = 0;
      if (ph == 5) outc = 65536;
      if (ph == 6) outc = 17'h1FFFF;
      program_regs(mode_t'($urandom_range(0, 3)), inc, outc, stride);
      if (ph == 3) hold_req++;
      repeat ($urandom_range(0, 10)) push_req(ACT_LOAD, rand_pcm());
      n_emit = (ph == 3) ? 40 : $urandom_range(8, 24);
      repeat (n_emit) begin
        if ($urandom_range(0, 99) < 10) push_req(ACT_LOAD, rand_pcm());
        push_req(ACT_EMIT, 16'($urandom));
      end
    end

    wait_idle();
    $display("Covered %0d loads and %0d emits over %0d register writes in four modes.",
             loads_taken, emits_taken, reg_writes);
    $display("Checked %0d results, %0d of them closing a pass.", results_seen, pass_ends);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
design/pcmr_pkg.sv
design/pcmr_ram.sv
design/pcm_resampler_interp_unit.sv
dv/pcm_resampler_interp_unit_tb.sv
